// File: hdl/rj_pkg.sv
`timescale 1ns / 1ps
package rj_pkg;

  // Default datapath format: Q15.16 in a 32-bit word
  localparam int RJ_WORD_WIDTH = 32;
  localparam int RJ_FRAC_BITS  = 16;

  // Multiplier digit: bits of the second operand consumed per stage
  localparam int RJ_MUL_DIGIT = 8;

  // Reset value of the range-squared threshold
  localparam int RJ_MIN_RANGE_SQ_RST = 7;

  // Control that follows an item down the pipe
  typedef struct packed {
    logic vld;
    logic near_zero;
    logic neg_x;
    logic neg_y;
    logic neg_d;
  } rj_ctl_t;

endpackage

// File: hdl/rj_dly.sv
`timescale 1ns / 1ps
module rj_dly #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] sr_r [DEPTH];

  // Shift the bundle one stage per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) sr_r[i] <= '0;
    end else begin
      sr_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) sr_r[i] <= sr_r[i-1];
    end
  end

  assign d_o = sr_r[DEPTH-1];

endmodule

// File: hdl/rj_mul.sv
`timescale 1ns / 1ps
module rj_mul import rj_pkg::*; #(
  parameter int AW  = 32,
  parameter int BW  = 32,
  parameter int DIG = RJ_MUL_DIGIT
) (
  input  logic             clk,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int NS = (BW + DIG - 1) / DIG;
  localparam int BP = NS * DIG;
  localparam int PW = AW + BW;

  logic [PW-1:0] acc_r [NS];
  logic [AW-1:0] a_r   [NS-1];
  logic [BP-1:0] b_r   [NS-1];

  // One digit of b per stage: narrow partial product plus a wide accumulate
  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [AW-1:0]     a_in;
    logic [BP-1:0]     b_in;
    logic [PW-1:0]     acc_in;
    logic [AW+DIG-1:0] pp;
    logic [PW-1:0]     acc_nxt;

    if (k == 0) begin : g_first
      assign a_in   = a_i;
      assign b_in   = BP'(b_i);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[k-1];
      assign b_in   = b_r[k-1];
      assign acc_in = acc_r[k-1];
    end

    assign pp      = (AW+DIG)'(a_in) * (AW+DIG)'(b_in[k*DIG +: DIG]);
    assign acc_nxt = acc_in + (PW'(pp) << (k * DIG));

    always_ff @(posedge clk) begin
      acc_r[k] <= acc_nxt;
    end

    if (k < NS - 1) begin : g_pass
      always_ff @(posedge clk) begin
        a_r[k] <= a_in;
        b_r[k] <= b_in;
      end
    end
  end

  assign p_o = acc_r[NS-1];

endmodule

// File: hdl/rj_rdiv.sv
`timescale 1ns / 1ps
module rj_rdiv #(
  parameter int QW = 32,
  parameter int NW = 64,
  parameter int DW = 64,
  parameter bit SQ = 1'b1
) (
  input  logic          clk,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  output logic [QW-1:0] q_o
);

  // Largest q in [0, 2^(QW-1)] with q*d <= n, or q*q*d <= n when SQ.
  // One result bit per stage; q*d and q*q*d are kept as running sums.
  localparam int XW = SQ ? (DW + 2 * QW) : (DW + QW);
  localparam int CW = ((NW > XW) ? NW : XW) + 2;

  logic [QW-1:0] q_r  [QW];
  logic [CW-1:0] a_r  [QW-1];
  logic [CW-1:0] bq_r [QW-1];
  logic [NW-1:0] n_r  [QW-1];
  logic [DW-1:0] d_r  [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [CW-1:0] a_in, bq_in, dx, t, a_nxt, bq_nxt;
    logic [QW-1:0] q_in, q_nxt;
    logic [NW-1:0] n_in;
    logic [DW-1:0] d_in;
    logic          take;

    if (k == 0) begin : g_first
      assign a_in  = '0;
      assign bq_in = '0;
      assign q_in  = '0;
      assign n_in  = n_i;
      assign d_in  = d_i;
    end else begin : g_next
      assign a_in  = a_r[k-1];
      assign bq_in = bq_r[k-1];
      assign q_in  = q_r[k-1];
      assign n_in  = n_r[k-1];
      assign d_in  = d_r[k-1];
    end

    assign dx = CW'(d_in);

    // Trial with bit B set; hold once q has reached the cap
    always_comb begin
      if (SQ) begin
        t = a_in + (bq_in << (B + 1)) + (dx << (2 * B));
      end else begin
        t = a_in + (dx << B);
      end
      take   = !q_in[QW-1] && (t <= CW'(n_in));
      a_nxt  = take ? t : a_in;
      bq_nxt = take ? (bq_in + (dx << B)) : bq_in;
      q_nxt  = take ? (q_in | (QW'(1) << B)) : q_in;
    end

    always_ff @(posedge clk) begin
      q_r[k] <= q_nxt;
    end

    if (k < QW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        a_r[k]  <= a_nxt;
        bq_r[k] <= bq_nxt;
        n_r[k]  <= n_in;
        d_r[k]  <= d_in;
      end
    end
  end

  assign q_o = q_r[QW-1];

endmodule

// File: hdl/radar_jacobian.sv
`timescale 1ns / 1ps
// Radar measurement Jacobian: one state vector (px, py, vx, vy) in, the six
// distinct nonzero entries out, exact to the truncated fixed-point result and
// saturated. The pipeline takes a new item every cycle (busy stays low); each
// result comes out of the digit-serial multiplier chain (squares, s^3, rate
// numerators) followed by the bit-per-stage root/divide units. Results
// appear for one cycle under out_strobe and cannot be held off, so they must
// be taken as they come. When px^2 + py^2 is zero or below min_range_sq (same
// Q format), all entries are zero and out_near_zero is set. cfg_ready is
// always high; write the threshold only while no item is in flight.
module radar_jacobian import rj_pkg::*; #(
  parameter int WORD_WIDTH = RJ_WORD_WIDTH,
  parameter int FRAC_BITS  = RJ_FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [WORD_WIDTH-1:0] in_pos_x,
  input  logic signed [WORD_WIDTH-1:0] in_pos_y,
  input  logic signed [WORD_WIDTH-1:0] in_vel_x,
  input  logic signed [WORD_WIDTH-1:0] in_vel_y,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic        [WORD_WIDTH-2:0] cfg_min_range_sq,
  output logic                         out_strobe,
  output logic signed [WORD_WIDTH-1:0] out_drange_dpx,
  output logic signed [WORD_WIDTH-1:0] out_drange_dpy,
  output logic signed [WORD_WIDTH-1:0] out_dbearing_dpx,
  output logic signed [WORD_WIDTH-1:0] out_dbearing_dpy,
  output logic signed [WORD_WIDTH-1:0] out_drate_dpx,
  output logic signed [WORD_WIDTH-1:0] out_drate_dpy,
  output logic                         out_near_zero
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DIG = RJ_MUL_DIGIT;
  localparam int L1  = (W + DIG - 1) / DIG;
  localparam int L2  = (2 * W + DIG - 1) / DIG;
  localparam int L3  = (3 * W + DIG - 1) / DIG;
  localparam int LAT = 3 + L1 + L2 + L3 + W;
  localparam int EW  = 5 + 2 * W;
  localparam int BW  = 8 * W;
  localparam int CT  = $bits(rj_ctl_t);

  logic acc;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  // Threshold register
  logic [W-2:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= (W-1)'(RJ_MIN_RANGE_SQ_RST);
    end else if (cfg_valid && cfg_ready) begin
      min_r <= cfg_min_range_sq;
    end
  end

  // Stage 0: sign and magnitude of each input beat
  logic         vld0_r;
  logic         nx_r, ny_r, nvx_r, nvy_r;
  logic [W-1:0] mx_r, my_r, mvx_r, mvy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      nx_r  <= in_pos_x[W-1];
      ny_r  <= in_pos_y[W-1];
      nvx_r <= in_vel_x[W-1];
      nvy_r <= in_vel_y[W-1];
      mx_r  <= in_pos_x[W-1] ? $unsigned(-in_pos_x) : $unsigned(in_pos_x);
      my_r  <= in_pos_y[W-1] ? $unsigned(-in_pos_y) : $unsigned(in_pos_y);
      mvx_r <= in_vel_x[W-1] ? $unsigned(-in_vel_x) : $unsigned(in_vel_x);
      mvy_r <= in_vel_y[W-1] ? $unsigned(-in_vel_y) : $unsigned(in_vel_y);
    end
  end

  // Products of the inputs
  logic [2*W-1:0] m_pp, m_qq, m_vyp, m_vxq;

  rj_mul #(.AW(W), .BW(W)) u_mul_pp  (.clk(clk), .a_i(mx_r),  .b_i(mx_r), .p_o(m_pp));
  rj_mul #(.AW(W), .BW(W)) u_mul_qq  (.clk(clk), .a_i(my_r),  .b_i(my_r), .p_o(m_qq));
  rj_mul #(.AW(W), .BW(W)) u_mul_vyp (.clk(clk), .a_i(mvy_r), .b_i(mx_r), .p_o(m_vyp));
  rj_mul #(.AW(W), .BW(W)) u_mul_vxq (.clk(clk), .a_i(mvx_r), .b_i(my_r), .p_o(m_vxq));

  logic [EW-1:0] e_bits;
  logic          e_vld, e_nx, e_ny, e_nvx, e_nvy;
  logic [W-1:0]  e_px, e_py;

  rj_dly #(.WIDTH(EW), .DEPTH(L1)) u_dly_early (
    .clk(clk), .rst_n(rst_n),
    .d_i({vld0_r, nx_r, ny_r, nvx_r, nvy_r, mx_r, my_r}),
    .d_o(e_bits)
  );

  assign {e_vld, e_nx, e_ny, e_nvx, e_nvy, e_px, e_py} = e_bits;

  // Stage 1: range squared, cross term, near-zero test
  logic [2*W-1:0] s_nxt, d_nxt, thr_ext;
  logic           nd_nxt, n1, n2;
  rj_ctl_t        ctl1_r;
  logic [2*W-1:0] s_r, d_r, p2_r, q2_r;
  logic [W-1:0]   px1_r, py1_r;

  assign thr_ext = (2*W)'({min_r, {F{1'b0}}});
  assign n1      = e_nvy ^ e_nx;
  assign n2      = e_nvx ^ e_ny;

  always_comb begin
    s_nxt = m_pp + m_qq;
    if (n1 != n2) begin
      d_nxt  = m_vyp + m_vxq;
      nd_nxt = n1;
    end else if (m_vyp >= m_vxq) begin
      d_nxt  = m_vyp - m_vxq;
      nd_nxt = n1;
    end else begin
      d_nxt  = m_vxq - m_vyp;
      nd_nxt = !n1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else begin
      ctl1_r.vld       <= e_vld;
      ctl1_r.near_zero <= (s_nxt == '0) || (s_nxt < thr_ext);
      ctl1_r.neg_x     <= e_nx;
      ctl1_r.neg_y     <= e_ny;
      ctl1_r.neg_d     <= nd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r   <= s_nxt;
    d_r   <= d_nxt;
    p2_r  <= m_pp;
    q2_r  <= m_qq;
    px1_r <= e_px;
    py1_r <= e_py;
  end

  // s^2 and the rate numerators |p|*|d|
  logic [4*W-1:0] m_ss;
  logic [3*W-1:0] m_qd, m_pd;
  logic [2*W-1:0] s_g3;

  rj_mul #(.AW(2*W), .BW(2*W)) u_mul_ss (.clk(clk), .a_i(s_r),   .b_i(s_r), .p_o(m_ss));
  rj_mul #(.AW(W),   .BW(2*W)) u_mul_qd (.clk(clk), .a_i(py1_r), .b_i(d_r), .p_o(m_qd));
  rj_mul #(.AW(W),   .BW(2*W)) u_mul_pd (.clk(clk), .a_i(px1_r), .b_i(d_r), .p_o(m_pd));

  rj_dly #(.WIDTH(2*W), .DEPTH(L2)) u_dly_s (
    .clk(clk), .rst_n(rst_n), .d_i(s_r), .d_o(s_g3)
  );

  // s^3 and the squared rate numerators
  logic [7*W-1:0] m_s3_full;
  logic [6*W-1:0] m_s3, m_xq2, m_xp2;

  rj_mul #(.AW(4*W), .BW(3*W)) u_mul_s3 (
    .clk(clk), .a_i(m_ss), .b_i((3*W)'(s_g3)), .p_o(m_s3_full)
  );
  rj_mul #(.AW(3*W), .BW(3*W)) u_mul_xq (.clk(clk), .a_i(m_qd), .b_i(m_qd), .p_o(m_xq2));
  rj_mul #(.AW(3*W), .BW(3*W)) u_mul_xp (.clk(clk), .a_i(m_pd), .b_i(m_pd), .p_o(m_xp2));

  assign m_s3 = m_s3_full[6*W-1:0];

  // Hold the early operands until the long products are done
  logic [BW-1:0]  b_bits;
  logic [2*W-1:0] sb, p2b, q2b;
  logic [W-1:0]   pxb, pyb;
  rj_ctl_t        ctl_d;

  rj_dly #(.WIDTH(BW), .DEPTH(L2 + L3)) u_dly_ops (
    .clk(clk), .rst_n(rst_n),
    .d_i({s_r, p2_r, q2_r, px1_r, py1_r}),
    .d_o(b_bits)
  );

  assign {sb, p2b, q2b, pxb, pyb} = b_bits;

  rj_dly #(.WIDTH(CT), .DEPTH(L2 + L3 + W)) u_dly_ctl (
    .clk(clk), .rst_n(rst_n), .d_i(ctl1_r), .d_o(ctl_d)
  );

  // Root and divide units, one per entry
  logic [W-1:0] q_mag [6];

  rj_rdiv #(.QW(W), .NW(2*W+2*F), .DW(2*W), .SQ(1'b1)) u_rd_rx (
    .clk(clk), .n_i({p2b, {(2*F){1'b0}}}), .d_i(sb), .q_o(q_mag[0])
  );
  rj_rdiv #(.QW(W), .NW(2*W+2*F), .DW(2*W), .SQ(1'b1)) u_rd_ry (
    .clk(clk), .n_i({q2b, {(2*F){1'b0}}}), .d_i(sb), .q_o(q_mag[1])
  );
  rj_rdiv #(.QW(W), .NW(W+2*F), .DW(2*W), .SQ(1'b0)) u_rd_bx (
    .clk(clk), .n_i({pyb, {(2*F){1'b0}}}), .d_i(sb), .q_o(q_mag[2])
  );
  rj_rdiv #(.QW(W), .NW(W+2*F), .DW(2*W), .SQ(1'b0)) u_rd_by (
    .clk(clk), .n_i({pxb, {(2*F){1'b0}}}), .d_i(sb), .q_o(q_mag[3])
  );
  rj_rdiv #(.QW(W), .NW(6*W+2*F), .DW(6*W), .SQ(1'b1)) u_rd_vx (
    .clk(clk), .n_i({m_xq2, {(2*F){1'b0}}}), .d_i(m_s3), .q_o(q_mag[4])
  );
  rj_rdiv #(.QW(W), .NW(6*W+2*F), .DW(6*W), .SQ(1'b1)) u_rd_vy (
    .clk(clk), .n_i({m_xp2, {(2*F){1'b0}}}), .d_i(m_s3), .q_o(q_mag[5])
  );

  // Apply sign and saturate
  function automatic logic [W-1:0] enc(input logic neg, input logic [W-1:0] mag);
    logic [W-1:0] r;
    if (mag == '0) begin
      r = '0;
    end else if (!neg) begin
      r = mag[W-1] ? {1'b0, {(W-1){1'b1}}} : mag;
    end else begin
      r = W'(-mag);
    end
    return r;
  endfunction

  logic         q_neg [6];
  logic [W-1:0] res_nxt [6];
  logic [W-1:0] res_r [6];
  logic         strobe_r, nz_r;

  always_comb begin
    q_neg[0] = ctl_d.neg_x;
    q_neg[1] = ctl_d.neg_y;
    q_neg[2] = !ctl_d.neg_y;
    q_neg[3] = ctl_d.neg_x;
    q_neg[4] = !(ctl_d.neg_y ^ ctl_d.neg_d);
    q_neg[5] = ctl_d.neg_x ^ ctl_d.neg_d;
    for (int i = 0; i < 6; i++) begin
      res_nxt[i] = ctl_d.near_zero ? '0 : enc(q_neg[i], q_mag[i]);
    end
  end

  // Output register: one beat per strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_d.vld;
    end
  end

  always_ff @(posedge clk) begin
    nz_r <= ctl_d.near_zero;
    for (int i = 0; i < 6; i++) res_r[i] <= res_nxt[i];
  end

  assign out_strobe       = strobe_r;
  assign out_near_zero    = nz_r;
  assign out_drange_dpx   = res_r[0];
  assign out_drange_dpy   = res_r[1];
  assign out_dbearing_dpx = res_r[2];
  assign out_dbearing_dpy = res_r[3];
  assign out_drate_dpx    = res_r[4];
  assign out_drate_dpy    = res_r[5];

  // Checks
  localparam logic signed [W-1:0] ONE_Q = W'(1) << F;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##LAT out_strobe)
    else $error("result beat missing at fixed latency");

  a_near_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_near_zero |->
      out_drange_dpx == '0 && out_drange_dpy == '0 &&
      out_dbearing_dpx == '0 && out_dbearing_dpy == '0 &&
      out_drate_dpx == '0 && out_drate_dpy == '0)
    else $error("nonzero entry with near-zero range");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_near_zero |->
      out_drange_dpx <= ONE_Q && out_drange_dpx >= -ONE_Q &&
      out_drange_dpy <= ONE_Q && out_drange_dpy >= -ONE_Q)
    else $error("range derivative beyond unit magnitude");

endmodule
